/* rtl/core/pnmp_pkg.sv */
// ----------------------------------------------------------------------------
// pnmp_pkg
// Shared types, constants and the character decode for the numeric packer.
// ----------------------------------------------------------------------------
package pnmp_pkg;

    localparam int          MAX_CHARS   = 41;
    localparam int          FRAME_WORDS = 88;
    localparam int          WORD_BITS   = 21;
    localparam int          IDX_W       = 4;
    localparam int          BIT_W       = 5;
    localparam logic [3:0]  FILL_CODE   = 4'hC;
    localparam logic [4:0]  START_BIT   = 5'd2;
    // last bit offset at which a whole nibble still fits in a word
    localparam logic [4:0]  LAST_SLOT   = 5'(WORD_BITS - 4);
    localparam logic [2:0]  VEC_TYPE    = 3'd3;
    localparam logic [5:0]  COUNT_MAX   = 6'd63;
    localparam logic        KIND_VECTOR  = 1'b0;
    localparam logic        KIND_MESSAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_FRAME    = 2'd3
    } t_status;

    typedef struct packed {
        logic             pack;
        logic             fill;
        logic             flush;
        logic             clear;
        logic [3:0]       nib;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_pack_ctl;

    typedef struct packed {
        logic [IDX_W-1:0] w;
        logic [BIT_W-1:0] b;
        logic [20:0]      rd_data;
    } t_pack_sts;

    // returns {valid, code}
    function automatic logic [4:0] digit_code(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else begin
            case (c)
                8'h41, 8'h53:        r = 5'h1A;  // A S
                8'h42, 8'h55:        r = 5'h1B;  // B U
                8'h20:               r = 5'h1C;  // space
                8'h43, 8'h2D:        r = 5'h1D;  // C -
                8'h44, 8'h29, 8'h5D: r = 5'h1E;  // D ) ]
                8'h45, 8'h28, 8'h5B: r = 5'h1F;  // E ( [
                default:             r = 5'h00;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/core/pnmp_pack.sv */
// ----------------------------------------------------------------------------
// pnmp_pack
// Nibble insert unit, open word register and message word store.
// ----------------------------------------------------------------------------
module pnmp_pack #(
    parameter int MAX_WORDS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pnmp_pkg::t_pack_ctl i_ctl,
    output pnmp_pkg::t_pack_sts o_sts
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [20:0]                  r_mem [MAX_WORDS];
    logic [20:0]                  r_rd_data;
    logic [20:0]                  r_open, n_open;
    logic [pnmp_pkg::IDX_W-1:0]   r_word, n_word;
    logic [pnmp_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [24:0]                  ins_wide;
    logic [20:0]                  ins_lo;
    logic [3:0]                   ins_hi;
    logic                         wr_en;
    logic [20:0]                  wr_data;
    logic                         word_in_store;

    // shared insert unit: bits above the word are the spill into the next one
    assign ins_wide = 25'(i_ctl.nib) << r_bit;
    assign ins_lo   = ins_wide[20:0];
    assign ins_hi   = ins_wide[24:21];

    assign word_in_store = (r_word < pnmp_pkg::IDX_W'(MAX_WORDS));

    always_comb begin
        n_open  = r_open;
        n_word  = r_word;
        n_bit   = r_bit;
        wr_en   = 1'b0;
        wr_data = r_open | ins_lo;
        if (i_ctl.clear) begin
            n_open = '0;
            n_word = '0;
            n_bit  = pnmp_pkg::START_BIT;
        end else if (i_ctl.pack) begin
            if (r_bit >= pnmp_pkg::LAST_SLOT) begin
                wr_en  = word_in_store;
                n_open = {17'd0, ins_hi};
                n_word = r_word + 1'b1;
                n_bit  = r_bit - pnmp_pkg::LAST_SLOT;
            end else begin
                n_open = r_open | ins_lo;
                n_bit  = r_bit + 5'd4;
            end
        end else if (i_ctl.fill) begin
            n_open = r_open | ins_lo;
            n_bit  = r_bit + 5'd4;
        end else if (i_ctl.flush) begin
            wr_en   = (r_bit != '0) && word_in_store;
            wr_data = r_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            r_word <= '0;
            r_bit  <= pnmp_pkg::START_BIT;
        end else begin
            r_open <= n_open;
            r_word <= n_word;
            r_bit  <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_word[AW-1:0]] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_idx[AW-1:0]];
        end
    end

    assign o_sts.w       = r_word;
    assign o_sts.b       = r_bit;
    assign o_sts.rd_data = r_rd_data;

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 5'(pnmp_pkg::WORD_BITS))
        else $error("bit offset beyond word");

    a_clear_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_bit == pnmp_pkg::START_BIT && r_word == '0 && r_open == '0))
        else $error("clear did not restart packing");

    a_fill_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.fill |-> (r_bit != '0 && r_bit <= pnmp_pkg::LAST_SLOT))
        else $error("fill nibble does not fit");

endmodule

/* rtl/core/pager_numeric_message_packer_top.sv */
// ----------------------------------------------------------------------------
// pager_numeric_message_packer_top
// Packs numeric message characters into 21-bit words and emits the vector
// word followed by the message words, or a single error result.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         start && !busy      i_char_code, i_message_start,
//                                          i_last_char
// result    out        o_strobe (1 cycle)  o_info_word, o_word_kind,
//                                          o_message_checksum, o_status,
//                                          o_last_word
//
// a character that is not last is packed in its transfer cycle; busy stays low
// the last character runs the sequencer: fill with the fill code, leave fill,
// flush, a checksum walk over the stored words through the store read port,
// checksum, vector, then one message word per cycle
// an error result leaves right after the flush cycle
// synchronous active-low reset; results cannot be held off by the receiver
// ----------------------------------------------------------------------------
module pager_numeric_message_packer_top #(
    parameter int MAX_WORDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_message_start,
    input  logic        i_last_char,
    output logic        o_strobe,
    output logic [20:0] o_info_word,
    output logic        o_word_kind,
    output logic [5:0]  o_message_checksum,
    output logic [1:0]  o_status,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_FLUSH,
        S_SUM,
        S_CKS,
        S_VEC,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic [5:0]                  r_count;
    logic                        r_err;
    logic [6:0]                  r_start;
    logic [pnmp_pkg::IDX_W-1:0]  r_nwords;
    logic [pnmp_pkg::IDX_W-1:0]  r_idx;
    logic [7:0]                  r_sum;
    logic [5:0]                  r_cks;

    pnmp_pkg::t_pack_ctl         ctl;
    pnmp_pkg::t_pack_sts         sts;

    logic                        accept;
    logic [4:0]                  dc;
    logic [5:0]                  cnt_inc;
    logic                        fill_go;
    logic [pnmp_pkg::IDX_W-1:0]  nwords_c;
    logic                        too_long;
    logic                        over_frame;
    logic                        err_any;
    pnmp_pkg::t_status           err_status;
    logic [7:0]                  word_sum;
    logic [6:0]                  tsum;
    logic [20:0]                 vec_base;
    logic [5:0]                  vec_nib;
    logic [20:0]                 vec_word;
    logic [pnmp_pkg::IDX_W-1:0]  idx_nxt;
    logic                        emit_last;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign dc      = pnmp_pkg::digit_code(i_char_code);
    assign cnt_inc = (r_count == pnmp_pkg::COUNT_MAX) ? r_count : r_count + 6'd1;

    assign fill_go  = (sts.b != '0) && (sts.b <= pnmp_pkg::LAST_SLOT);
    assign nwords_c = (sts.b == '0) ? sts.w : sts.w + 1'b1;

    assign too_long   = (r_count > 6'(pnmp_pkg::MAX_CHARS))
                     || (nwords_c > pnmp_pkg::IDX_W'(MAX_WORDS));
    assign over_frame = ({1'b0, r_start} + {4'd0, nwords_c}) > 8'(pnmp_pkg::FRAME_WORDS);
    assign err_any    = too_long || r_err || over_frame;

    always_comb begin
        if (too_long) begin
            err_status = pnmp_pkg::ST_TOO_LONG;
        end else if (r_err) begin
            err_status = pnmp_pkg::ST_BAD_CHAR;
        end else if (over_frame) begin
            err_status = pnmp_pkg::ST_FRAME;
        end else begin
            err_status = pnmp_pkg::ST_OK;
        end
    end

    // checksum fields of one stored word
    assign word_sum = 8'({1'b0, sts.rd_data[7:0]} + {1'b0, sts.rd_data[15:8]}
                         + {4'd0, sts.rd_data[20:16]});
    assign tsum     = {1'b0, r_sum[5:0]} + {5'd0, r_sum[7:6]};

    assign vec_base = {r_cks[3:0], 3'(r_nwords - 1'b1), r_start, pnmp_pkg::VEC_TYPE, 4'd0};
    assign vec_nib  = {2'd0, vec_base[7:4]} + {2'd0, vec_base[11:8]}
                    + {2'd0, vec_base[15:12]} + {2'd0, vec_base[19:16]}
                    + {5'd0, vec_base[20]};
    assign vec_word = {vec_base[20:4], ~vec_nib[3:0]};

    assign idx_nxt   = r_idx + 1'b1;
    assign emit_last = (idx_nxt == r_nwords);

    always_comb begin
        ctl        = '0;
        ctl.nib    = (r_state == S_IDLE) ? dc[3:0] : pnmp_pkg::FILL_CODE;
        ctl.rd_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                ctl.pack = accept && dc[4] && !r_err
                        && (cnt_inc <= 6'(pnmp_pkg::MAX_CHARS));
            end
            S_FILL: begin
                ctl.fill = fill_go;
            end
            S_FLUSH: begin
                ctl.flush = 1'b1;
                ctl.clear = err_any;
            end
            S_SUM: begin
                ctl.rd_en = (r_idx < r_nwords);
            end
            S_VEC: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_idx = '0;
            end
            S_EMIT: begin
                ctl.rd_en  = (idx_nxt < r_nwords);
                ctl.rd_idx = idx_nxt;
                ctl.clear  = emit_last;
            end
            default: begin
                ctl.clear = 1'b0;
            end
        endcase
    end

    pnmp_pack #(
        .MAX_WORDS (MAX_WORDS)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= 1'b0;
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_strobe <= 1'b0;
                    if (accept) begin
                        r_count <= cnt_inc;
                        if (!dc[4]) begin
                            r_err <= 1'b1;
                        end
                        if (i_last_char) begin
                            r_start <= i_message_start;
                            r_state <= S_FILL;
                        end
                    end
                end
                S_FILL: begin
                    o_strobe <= 1'b0;
                    if (!fill_go) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    o_strobe <= err_any;
                    r_nwords <= nwords_c;
                    r_idx    <= '0;
                    r_sum    <= '0;
                    if (err_any) begin
                        o_info_word        <= '0;
                        o_word_kind        <= pnmp_pkg::KIND_VECTOR;
                        o_message_checksum <= '0;
                        o_status           <= err_status;
                        o_last_word        <= 1'b1;
                        r_count            <= '0;
                        r_err              <= 1'b0;
                        r_state            <= S_IDLE;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    o_strobe <= 1'b0;
                    // read data arrives in the cycle after its address
                    if (r_idx != '0) begin
                        r_sum <= r_sum + word_sum;
                    end
                    r_idx <= idx_nxt;
                    if (r_idx == r_nwords) begin
                        r_state <= S_CKS;
                    end
                end
                S_CKS: begin
                    o_strobe <= 1'b0;
                    r_cks    <= ~tsum[5:0];
                    r_state  <= S_VEC;
                end
                S_VEC: begin
                    o_strobe           <= 1'b1;
                    o_info_word        <= vec_word;
                    o_word_kind        <= pnmp_pkg::KIND_VECTOR;
                    o_message_checksum <= r_cks;
                    o_status           <= pnmp_pkg::ST_OK;
                    o_last_word        <= (r_nwords == '0);
                    r_idx              <= '0;
                    r_state            <= S_EMIT;
                end
                S_EMIT: begin
                    o_strobe           <= 1'b1;
                    o_info_word        <= sts.rd_data
                                        | {19'd0, (r_idx == '0) ? r_cks[5:4] : 2'd0};
                    o_word_kind        <= pnmp_pkg::KIND_MESSAGE;
                    o_message_checksum <= r_cks;
                    o_status           <= pnmp_pkg::ST_OK;
                    o_last_word        <= emit_last;
                    r_idx              <= idx_nxt;
                    if (emit_last) begin
                        r_count <= '0;
                        r_err   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != pnmp_pkg::ST_OK) |-> (o_last_word && o_info_word == '0))
        else $error("error result is not a lone zero word");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_char) |=> busy)
        else $error("last character did not start the sequencer");

    a_vec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word_kind == pnmp_pkg::KIND_VECTOR && o_status == pnmp_pkg::ST_OK)
        |-> !o_last_word)
        else $error("vector word closed the run");

    a_sum_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_idx <= r_nwords))
        else $error("checksum walk past word count");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_word) |-> !busy)
        else $error("sequencer still busy after final result");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the numeric message packer. It sends character
// streams over the start/busy handshake. A bit-level model of the packing
// predicts the vector and message words, or the single error result, for
// each message. Every strobed result is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MSG_WORDS     = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 1000;
    localparam int CHARS_TOTAL   = 200;

    typedef struct packed {
        logic [20:0]       info;
        logic              kind;
        logic [5:0]        cks;
        pnmp_pkg::t_status status;
        logic              last;
    } t_word_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [7:0]  i_char_code     = 8'h00;
    logic [6:0]  i_message_start = 7'd0;
    logic        i_last_char     = 1'b0;
    logic        busy;
    logic        o_strobe;
    logic [20:0] o_info_word;
    logic        o_word_kind;
    logic [5:0]  o_message_checksum;
    logic [1:0]  o_status;
    logic        o_last_word;

    // packing image: word i lives at bits 21*i +: 21
    logic [MSG_WORDS*pnmp_pkg::WORD_BITS-1:0] msg_bits;
    int             bit_pos;
    int             char_count;
    logic           saw_bad_char;
    t_word_result   expected_words[$];
    int             errors       = 0;
    int             chars_sent   = 0;
    int             stall_cycles = 0;
    logic           idling       = 1'b0;
    string          valid_chars  = "0123456789ASBU C-D)]E([";

    pager_numeric_message_packer_top #(
        .MAX_WORDS(MSG_WORDS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_char_code       (i_char_code),
        .i_message_start   (i_message_start),
        .i_last_char       (i_last_char),
        .o_strobe          (o_strobe),
        .o_info_word       (o_info_word),
        .o_word_kind       (o_word_kind),
        .o_message_checksum(o_message_checksum),
        .o_status          (o_status),
        .o_last_word       (o_last_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int char_to_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        case (c)
            "A", "S":      return 10;
            "B", "U":      return 11;
            " ":           return 12;
            "C", "-":      return 13;
            "D", ")", "]": return 14;
            "E", "(", "[": return 15;
            default:       return -1;
        endcase
    endfunction

    task automatic clear_message();
        msg_bits     = '0;
        bit_pos      = int'(pnmp_pkg::START_BIT);
        char_count   = 0;
        saw_bad_char = 1'b0;
    endtask

    task automatic queue_result(input logic [20:0] info, input logic kind,
                                input logic [5:0] cks, input pnmp_pkg::t_status st,
                                input logic lst);
        t_word_result r;
        r.info   = info;
        r.kind   = kind;
        r.cks    = cks;
        r.status = st;
        r.last   = lst;
        expected_words = {expected_words, r};
    endtask

    // packs one character and, on the last one, queues the words it releases
    task automatic predict_char(input logic [7:0] c, input logic [6:0] ms, input logic lst);
        int                code;
        int                wd;
        int                bt;
        int                nwords;
        int                sum;
        int                tsum;
        int                nib;
        int                i;
        logic [5:0]        cks;
        logic [20:0]       vec;
        logic [20:0]       mw;
        pnmp_pkg::t_status st;
        code = char_to_digit(c);
        if (char_count < 63) char_count++;
        if (code < 0) begin
            saw_bad_char = 1'b1;
        end else if (!saw_bad_char && char_count <= pnmp_pkg::MAX_CHARS) begin
            msg_bits[bit_pos +: 4] = 4'(code);
            bit_pos = (bit_pos + 4) % 256;
        end
        if (!lst) return;

        wd = bit_pos / pnmp_pkg::WORD_BITS;
        bt = bit_pos % pnmp_pkg::WORD_BITS;
        if (bt == 0) begin
            nwords = wd;
        end else begin
            for (; bt <= pnmp_pkg::WORD_BITS - 4; bt += 4) begin
                msg_bits[wd*pnmp_pkg::WORD_BITS + bt +: 4] = pnmp_pkg::FILL_CODE;
            end
            nwords = wd + 1;
        end

        st = pnmp_pkg::ST_OK;
        if (char_count > pnmp_pkg::MAX_CHARS || nwords > MSG_WORDS) begin
            st = pnmp_pkg::ST_TOO_LONG;
        end else if (saw_bad_char) begin
            st = pnmp_pkg::ST_BAD_CHAR;
        end else if (int'(ms) + nwords > pnmp_pkg::FRAME_WORDS) begin
            st = pnmp_pkg::ST_FRAME;
        end

        if (st != pnmp_pkg::ST_OK) begin
            queue_result(21'd0, pnmp_pkg::KIND_VECTOR, 6'd0, st, 1'b1);
        end else begin
            sum = 0;
            for (i = 0; i < nwords; i++) begin
                mw = msg_bits[i*pnmp_pkg::WORD_BITS +: pnmp_pkg::WORD_BITS];
                sum += mw[7:0] + mw[15:8] + mw[20:16];
            end
            sum  = sum % 256;
            tsum = sum % 64 + sum / 64;
            cks  = ~6'(tsum);
            msg_bits[1:0] = msg_bits[1:0] | cks[5:4];
            vec = {cks[3:0], 3'(nwords - 1), ms, pnmp_pkg::VEC_TYPE, 4'b0000};
            nib = vec[7:4] + vec[11:8] + vec[15:12] + vec[19:16] + vec[20];
            vec[3:0] = ~4'(nib);
            queue_result(vec, pnmp_pkg::KIND_VECTOR, cks, pnmp_pkg::ST_OK, 1'b0);
            for (i = 0; i < nwords; i++) begin
                queue_result(msg_bits[i*pnmp_pkg::WORD_BITS +: pnmp_pkg::WORD_BITS],
                             pnmp_pkg::KIND_MESSAGE, cks, pnmp_pkg::ST_OK,
                             1'(i == nwords - 1));
            end
        end
        clear_message();
    endtask

    task automatic send_char(input logic [7:0] c, input logic [6:0] ms, input logic lst);
        int gap;
        gap = idling ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_char_code     <= c;
        i_message_start <= ms;
        i_last_char     <= lst;
        do @(posedge i_clk); while (busy);
        predict_char(c, ms, lst);
        chars_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // every character code once, back to back, with fill and straddling words
    task automatic test_every_code();
        int i;
        idling = 1'b0;
        for (i = 0; i < valid_chars.len(); i++) begin
            send_char(valid_chars[i], (i == valid_chars.len() - 1) ? 7'd65 : 7'($urandom),
                      i == valid_chars.len() - 1);
        end
        wait_for_results();
    endtask

    task automatic test_error_paths();
        idling = 1'b1;
        send_char(8'hFF, 7'd127, 1'b1);
        // single word ending exactly on the frame end, then one beyond it
        send_char("9", 7'd87, 1'b1);
        send_char("0", 7'd127, 1'b1);
        // characters after a bad one are counted but not packed
        send_char("1", 7'd0, 1'b0);
        send_char(8'h00, 7'd0, 1'b0);
        send_char("2", 7'd0, 1'b1);
    endtask

    task automatic test_random_messages();
        int         kind;
        int         len;
        int         i;
        logic [6:0] ms;
        logic [7:0] c;
        while (chars_sent < CHARS_TOTAL) begin
            idling = ($urandom_range(0, 3) != 0);
            kind   = $urandom_range(0, 99);
            if (kind < 8) len = $urandom_range(pnmp_pkg::MAX_CHARS + 1, 70);
            else if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 12);
            else len = $urandom_range(13, pnmp_pkg::MAX_CHARS);
            if ($urandom_range(0, 99) < 80) ms = 7'($urandom_range(0, 80));
            else ms = 7'($urandom_range(0, 127));
            for (i = 0; i < len; i++) begin
                if (kind < 20 && $urandom_range(0, 4) == 0) begin
                    do c = 8'($urandom); while (char_to_digit(c) >= 0);
                end else begin
                    c = valid_chars[$urandom_range(0, valid_chars.len() - 1)];
                end
                send_char(c, (i == len - 1) ? ms : 7'($urandom), i == len - 1);
            end
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_word_result got;
        t_word_result want;
        if (i_rst_n && o_strobe) begin
            got = {o_info_word, o_word_kind, o_message_checksum, o_status, o_last_word};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result info=%h kind=%0d cks=%h st=%0d last=%0d",
                         $time, got.info, got.kind, got.cks, got.status, got.last);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t: expected info=%h kind=%0d cks=%h st=%0d last=%0d",
                             $time, want.info, want.kind, want.cks, want.status, want.last);
                    $display("%0t: actual   info=%h kind=%0d cks=%h st=%0d last=%0d",
                             $time, got.info, got.kind, got.cks, got.status, got.last);
                    errors++;
                end
            end
        end
    end

    // cycles with neither an input transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        clear_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_every_code();
        test_error_paths();
        test_random_messages();
        wait_for_results();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
